/* hdl/ofta_pkg.sv */
// ---------------------------------------------------------------------------
// ofta_pkg: shared types and constants for the oblique-frame torsion angle
// Word formats, arithmetic widths, status codes and the arctangent table.
// ---------------------------------------------------------------------------
`default_nettype none

package ofta_pkg;

	localparam int COORD_BITS      = 16;
	localparam int ANGLE_FRAC_BITS = 7;
	localparam int ANGLE_W         = 15;
	localparam int STATUS_W        = 2;

	// difference, cross product, pairwise product and dot product widths
	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int CROSS_W = 2 * DIFF_W + 1;
	localparam int PROD_W  = 2 * CROSS_W;
	localparam int DOT_W   = PROD_W + 2;
	localparam int LEN_W   = $clog2(DOT_W + 1);

	localparam int KEEP_BITS = 30;
	localparam int SQ_W      = 2 * KEEP_BITS;
	localparam int ROOT_W    = KEEP_BITS + 2;
	localparam int RAD_W     = 2 * ROOT_W;
	localparam int REM_W     = ROOT_W + 2;
	localparam int SQRT_STAGES = ROOT_W / 2;

	localparam int CFRAC    = 20;
	localparam int CSTEPS   = 24;
	localparam int CORDIC_STAGES = CSTEPS / 2;
	localparam int CD_W     = KEEP_BITS + 4;
	localparam int Z_W      = 29;
	localparam int ZC_W     = Z_W - 2;
	localparam int TOT_W    = ZC_W + 1;
	localparam int ROUND_SH = CFRAC - ANGLE_FRAC_BITS;

	localparam logic [ZC_W-1:0]  Z_DEG90   = ZC_W'(90) << CFRAC;
	localparam logic [TOT_W-1:0] Z_DEG180  = TOT_W'(180) << CFRAC;
	localparam logic [TOT_W:0]   ROUND_HALF = (TOT_W+1)'(1) << (ROUND_SH - 1);
	localparam logic [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(180) << ANGLE_FRAC_BITS;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SINGULAR = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO_VEC = 2'd2;

	// atan(2^-i) in degrees scaled by 2^CFRAC
	localparam logic [Z_W-1:0] ATAN_DEG [CSTEPS] = '{
		29'd47185920, 29'd27855475, 29'd14718068, 29'd7471121, 29'd3750058,
		29'd1876857, 29'd938658, 29'd469357, 29'd234682, 29'd117342,
		29'd58671, 29'd29335, 29'd14668, 29'd7334, 29'd3667, 29'd1833,
		29'd917, 29'd458, 29'd229, 29'd115, 29'd57, 29'd29, 29'd14, 29'd7
	};

	typedef struct packed {
		logic signed [COORD_BITS-1:0] p0_x;
		logic signed [COORD_BITS-1:0] p0_y;
		logic signed [COORD_BITS-1:0] p0_z;
		logic signed [COORD_BITS-1:0] p1_x;
		logic signed [COORD_BITS-1:0] p1_y;
		logic signed [COORD_BITS-1:0] p1_z;
		logic signed [COORD_BITS-1:0] p2_x;
		logic signed [COORD_BITS-1:0] p2_y;
		logic signed [COORD_BITS-1:0] p2_z;
		logic signed [COORD_BITS-1:0] p3_x;
		logic signed [COORD_BITS-1:0] p3_y;
		logic signed [COORD_BITS-1:0] p3_z;
	} in_word_t;

	typedef struct packed {
		logic [ANGLE_W-1:0]  angle_out;
		logic [STATUS_W-1:0] status_code;
	} out_word_t;

	// flags that ride along with a word through the pipeline
	typedef struct packed {
		logic singular;
		logic zero_v;
		logic neg0;
	} ctl_t;

endpackage

`default_nettype wire

/* hdl/ofta_in_if.sv */
// ---------------------------------------------------------------------------
// ofta_in_if: point channel
// Valid/ready channel carrying four 3D points per word.
// ---------------------------------------------------------------------------
`default_nettype none

interface ofta_in_if;
	import ofta_pkg::*;

	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/ofta_out_if.sv */
// ---------------------------------------------------------------------------
// ofta_out_if: angle channel
// Valid/ready channel carrying one angle and status per word.
// ---------------------------------------------------------------------------
`default_nettype none

interface ofta_out_if;
	import ofta_pkg::*;

	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/oblique_frame_torsion_angle.sv */
// Each point word runs through s1 to s9, the square root, the CORDIC and word_q.
// Throughput: one word per cycle when res.ready is high; every stage has its
// own valid bit and loads whenever it is empty or its successor loads, so
// stalls squeeze out bubbles. Depth is set by the 16-stage square root and the
// 12-stage CORDIC. Reset clears all valid bits; data registers are not reset.
// ---------------------------------------------------------------------------
// oblique_frame_torsion_angle: torsion angle in an oblique frame
// Builds a basis from three points, maps the fourth difference through the
// adjugate and reports its angle to the x axis with a status code.
// ---------------------------------------------------------------------------
`default_nettype none

module oblique_frame_torsion_angle (
	input wire         clk,
	input wire         arst_n,
	ofta_in_if.sink    pts,
	ofta_out_if.source res
);
	import ofta_pkg::*;

	function automatic logic signed [CROSS_W-1:0] xterm(
			input logic signed [DIFF_W-1:0] p, input logic signed [DIFF_W-1:0] q,
			input logic signed [DIFF_W-1:0] r, input logic signed [DIFF_W-1:0] s);
		logic signed [CROSS_W-1:0] pq;
		logic signed [CROSS_W-1:0] rs;
		pq = CROSS_W'(p) * CROSS_W'(q);
		rs = CROSS_W'(r) * CROSS_W'(s);
		return pq - rs;
	endfunction

	function automatic logic signed [DIFF_W-1:0] dif(
			input logic signed [COORD_BITS-1:0] h, input logic signed [COORD_BITS-1:0] l);
		return DIFF_W'(h) - DIFF_W'(l);
	endfunction

	// s1: differences a = p0-p1, c = p2-p1, v = p3-p2
	logic                      vld_s1;
	logic signed [DIFF_W-1:0]  a_s1 [3];
	logic signed [DIFF_W-1:0]  c_s1 [3];
	logic signed [DIFF_W-1:0]  v_s1 [3];
	// s2: b = c x a, u1 = c x v, u2 = v x a
	logic                      vld_s2;
	logic signed [CROSS_W-1:0] b_s2 [3];
	logic signed [CROSS_W-1:0] u1_s2 [3];
	logic signed [CROSS_W-1:0] u2_s2 [3];
	logic signed [DIFF_W-1:0]  v_s2 [3];
	ctl_t                      ctl_s2;
	// s3: products for b.u1, b.v, b.u2
	logic                      vld_s3;
	logic signed [PROD_W-1:0]  p0_s3 [3];
	logic signed [PROD_W-1:0]  p1_s3 [3];
	logic signed [PROD_W-1:0]  p2_s3 [3];
	ctl_t                      ctl_s3;
	// s4: sums
	logic                      vld_s4;
	logic signed [DOT_W-1:0]   w_s4 [3];
	ctl_t                      ctl_s4;
	// s5: magnitudes
	logic                      vld_s5;
	logic [DOT_W-1:0]          m_s5 [3];
	ctl_t                      ctl_s5;
	// s6: shift amount
	logic                      vld_s6;
	logic [DOT_W-1:0]          m_s6 [3];
	logic [LEN_W-1:0]          sh_s6;
	ctl_t                      ctl_s6;
	// s7: scaled values
	logic                      vld_s7;
	logic [KEEP_BITS-1:0]      k_s7 [3];
	ctl_t                      ctl_s7;
	// s8: squares
	logic                      vld_s8;
	logic [KEEP_BITS-1:0]      x_s8;
	logic [SQ_W-1:0]           q1_s8;
	logic [SQ_W-1:0]           q2_s8;
	ctl_t                      ctl_s8;
	// s9: radicand
	logic                      vld_s9;
	logic [KEEP_BITS-1:0]      x_s9;
	logic [RAD_W-1:0]          rad_s9;
	ctl_t                      ctl_s9;
	// output register
	logic                      vld_q;
	out_word_t                 word_q;

	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8, rdy9, rdy_o;
	logic sq_in_ready, sq_out_valid, cd_in_ready, cd_out_valid;
	logic [ROOT_W-1:0]    sq_root;
	logic [KEEP_BITS-1:0] sq_x;
	ctl_t                 sq_ctl;
	ctl_t                 cd_ctl;
	logic signed [Z_W-1:0] cd_z;

	logic [LEN_W-1:0]  len_c;
	logic [DOT_W-1:0]  mor_c;
	logic [ZC_W-1:0]   zc_c;
	logic [TOT_W-1:0]  tot_c;
	logic [TOT_W:0]    rnd_c;
	out_word_t         word_c;

	assign rdy_o = !vld_q || res.ready;
	assign rdy9  = !vld_s9 || sq_in_ready;
	assign rdy8  = !vld_s8 || rdy9;
	assign rdy7  = !vld_s7 || rdy8;
	assign rdy6  = !vld_s6 || rdy7;
	assign rdy5  = !vld_s5 || rdy6;
	assign rdy4  = !vld_s4 || rdy5;
	assign rdy3  = !vld_s3 || rdy4;
	assign rdy2  = !vld_s2 || rdy3;
	assign rdy1  = !vld_s1 || rdy2;
	assign pts.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= pts.valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
			if (rdy6) vld_s6 <= vld_s5;
			if (rdy7) vld_s7 <= vld_s6;
			if (rdy8) vld_s8 <= vld_s7;
			if (rdy9) vld_s9 <= vld_s8;
			if (rdy_o) vld_q <= cd_out_valid;
		end
	end

	// leading one over the three magnitudes
	always_comb begin
		mor_c = m_s5[0] | m_s5[1] | m_s5[2];
		len_c = '0;
		for (int i = 0; i < DOT_W; i++) begin
			if (mor_c[i]) len_c = LEN_W'(i + 1);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			a_s1[0] <= dif(pts.data.p0_x, pts.data.p1_x);
			a_s1[1] <= dif(pts.data.p0_y, pts.data.p1_y);
			a_s1[2] <= dif(pts.data.p0_z, pts.data.p1_z);
			c_s1[0] <= dif(pts.data.p2_x, pts.data.p1_x);
			c_s1[1] <= dif(pts.data.p2_y, pts.data.p1_y);
			c_s1[2] <= dif(pts.data.p2_z, pts.data.p1_z);
			v_s1[0] <= dif(pts.data.p3_x, pts.data.p2_x);
			v_s1[1] <= dif(pts.data.p3_y, pts.data.p2_y);
			v_s1[2] <= dif(pts.data.p3_z, pts.data.p2_z);
		end
		if (rdy2) begin
			b_s2[0]  <= xterm(c_s1[1], a_s1[2], c_s1[2], a_s1[1]);
			b_s2[1]  <= xterm(c_s1[2], a_s1[0], c_s1[0], a_s1[2]);
			b_s2[2]  <= xterm(c_s1[0], a_s1[1], c_s1[1], a_s1[0]);
			u1_s2[0] <= xterm(c_s1[1], v_s1[2], c_s1[2], v_s1[1]);
			u1_s2[1] <= xterm(c_s1[2], v_s1[0], c_s1[0], v_s1[2]);
			u1_s2[2] <= xterm(c_s1[0], v_s1[1], c_s1[1], v_s1[0]);
			u2_s2[0] <= xterm(v_s1[1], a_s1[2], v_s1[2], a_s1[1]);
			u2_s2[1] <= xterm(v_s1[2], a_s1[0], v_s1[0], a_s1[2]);
			u2_s2[2] <= xterm(v_s1[0], a_s1[1], v_s1[1], a_s1[0]);
			v_s2     <= v_s1;
			ctl_s2.singular <= 1'b0;
			ctl_s2.zero_v   <= (v_s1[0] == '0) && (v_s1[1] == '0) && (v_s1[2] == '0);
			ctl_s2.neg0     <= 1'b0;
		end
		// det of [a b c] is |b|^2, so the basis is singular exactly when b is zero
		if (rdy3) begin
			for (int i = 0; i < 3; i++) begin
				p0_s3[i] <= PROD_W'(b_s2[i]) * PROD_W'(u1_s2[i]);
				p1_s3[i] <= PROD_W'(b_s2[i]) * PROD_W'(v_s2[i]);
				p2_s3[i] <= PROD_W'(b_s2[i]) * PROD_W'(u2_s2[i]);
			end
			ctl_s3.singular <= (b_s2[0] == '0) && (b_s2[1] == '0) && (b_s2[2] == '0);
			ctl_s3.zero_v   <= ctl_s2.zero_v;
			ctl_s3.neg0     <= ctl_s2.neg0;
		end
		if (rdy4) begin
			w_s4[0] <= DOT_W'(p0_s3[0]) + DOT_W'(p0_s3[1]) + DOT_W'(p0_s3[2]);
			w_s4[1] <= DOT_W'(p1_s3[0]) + DOT_W'(p1_s3[1]) + DOT_W'(p1_s3[2]);
			w_s4[2] <= DOT_W'(p2_s3[0]) + DOT_W'(p2_s3[1]) + DOT_W'(p2_s3[2]);
			ctl_s4  <= ctl_s3;
		end
		if (rdy5) begin
			for (int i = 0; i < 3; i++) begin
				m_s5[i] <= w_s4[i][DOT_W-1] ? DOT_W'(-w_s4[i]) : DOT_W'(w_s4[i]);
			end
			ctl_s5.singular <= ctl_s4.singular;
			ctl_s5.zero_v   <= ctl_s4.zero_v;
			ctl_s5.neg0     <= w_s4[0][DOT_W-1];
		end
		if (rdy6) begin
			m_s6   <= m_s5;
			sh_s6  <= (len_c > LEN_W'(KEEP_BITS)) ? len_c - LEN_W'(KEEP_BITS) : '0;
			ctl_s6 <= ctl_s5;
		end
		if (rdy7) begin
			for (int i = 0; i < 3; i++) begin
				k_s7[i] <= KEEP_BITS'(m_s6[i] >> sh_s6);
			end
			ctl_s7 <= ctl_s6;
		end
		if (rdy8) begin
			x_s8   <= k_s7[0];
			q1_s8  <= SQ_W'(k_s7[1]) * SQ_W'(k_s7[1]);
			q2_s8  <= SQ_W'(k_s7[2]) * SQ_W'(k_s7[2]);
			ctl_s8 <= ctl_s7;
		end
		if (rdy9) begin
			x_s9   <= x_s8;
			rad_s9 <= RAD_W'(q1_s8) + RAD_W'(q2_s8);
			ctl_s9 <= ctl_s8;
		end
		if (rdy_o) word_q <= word_c;
	end

	ofta_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s9),
		.in_ready  (sq_in_ready),
		.rad       (rad_s9),
		.x_in      (x_s9),
		.ctl_in    (ctl_s9),
		.out_valid (sq_out_valid),
		.out_ready (cd_in_ready),
		.root      (sq_root),
		.x_out     (sq_x),
		.ctl_out   (sq_ctl)
	);

	ofta_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_out_valid),
		.in_ready  (cd_in_ready),
		.x_in      (sq_x),
		.y_in      (sq_root),
		.ctl_in    (sq_ctl),
		.out_valid (cd_out_valid),
		.out_ready (rdy_o),
		.z_out     (cd_z),
		.ctl_out   (cd_ctl)
	);

	// clamp to [0, 90], mirror for negative x, round half up
	always_comb begin
		if (cd_z < 0) zc_c = '0;
		else if (cd_z > $signed(Z_W'(Z_DEG90))) zc_c = Z_DEG90;
		else zc_c = ZC_W'(cd_z);
		tot_c = cd_ctl.neg0 ? Z_DEG180 - TOT_W'(zc_c) : TOT_W'(zc_c);
		rnd_c = ((TOT_W+1)'(tot_c) + ROUND_HALF) >> ROUND_SH;
		if (cd_ctl.singular) begin
			word_c.angle_out   = '0;
			word_c.status_code = ST_SINGULAR;
		end else if (cd_ctl.zero_v) begin
			word_c.angle_out   = '0;
			word_c.status_code = ST_ZERO_VEC;
		end else begin
			word_c.angle_out   = rnd_c[ANGLE_W-1:0];
			word_c.status_code = ST_OK;
		end
	end

	assign res.valid = vld_q;
	assign res.data  = word_q;

`ifndef SYNTH
	a_err_zero_angle: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.status_code != ST_OK |-> res.data.angle_out == '0)
		else $error("nonzero angle with error status");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.status_code == ST_OK |-> res.data.angle_out <= ANGLE_MAX)
		else $error("angle above 180 degrees");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!pts.ready |-> res.valid && !res.ready)
		else $error("input stalled while pipeline can drain");

	a_zero_v_flag: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && ctl_s2.zero_v |-> v_s2[0] == '0 && v_s2[1] == '0 && v_s2[2] == '0)
		else $error("zero vector flag set for nonzero vector");
`endif

endmodule

`default_nettype wire

/* hdl/ofta_sqrt.sv */
// ---------------------------------------------------------------------------
// ofta_sqrt: pipelined integer square root
// Floor square root, two result bits per stage, flags and x carried along.
// ---------------------------------------------------------------------------
`default_nettype none

module ofta_sqrt (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [ofta_pkg::RAD_W-1:0]     rad,
	input  wire  [ofta_pkg::KEEP_BITS-1:0] x_in,
	input  ofta_pkg::ctl_t               ctl_in,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [ofta_pkg::ROOT_W-1:0]    root,
	output logic [ofta_pkg::KEEP_BITS-1:0] x_out,
	output ofta_pkg::ctl_t               ctl_out
);
	import ofta_pkg::*;

	typedef struct packed {
		logic [REM_W-1:0]     rem;
		logic [ROOT_W-1:0]    root;
		logic [RAD_W-1:0]     rad;
		logic [KEEP_BITS-1:0] x;
		ctl_t                 ctl;
	} sq_t;

	sq_t  stg_s [SQRT_STAGES];
	logic vld_s [SQRT_STAGES];
	logic rdy   [SQRT_STAGES];
	sq_t  nxt   [SQRT_STAGES];

	function automatic sq_t sq_stage(input sq_t s);
		sq_t              r;
		logic [REM_W-1:0] rm;
		logic [REM_W-1:0] t;
		r = s;
		for (int k = 0; k < 2; k++) begin
			rm = {r.rem[REM_W-3:0], r.rad[RAD_W-1 -: 2]};
			t  = {r.root, 2'b01};
			r.rad = {r.rad[RAD_W-3:0], 2'b00};
			if (rm >= t) begin
				r.rem  = rm - t;
				r.root = {r.root[ROOT_W-2:0], 1'b1};
			end else begin
				r.rem  = rm;
				r.root = {r.root[ROOT_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	always_comb begin
		sq_t src;
		for (int g = 0; g < SQRT_STAGES; g++) begin
			if (g == 0) begin
				src.rem  = '0;
				src.root = '0;
				src.rad  = rad;
				src.x    = x_in;
				src.ctl  = ctl_in;
			end else begin
				src = stg_s[g-1];
			end
			nxt[g] = sq_stage(src);
		end
	end

	// a stage loads when it is empty or its successor loads
	always_comb begin
		for (int g = SQRT_STAGES - 1; g >= 0; g--) begin
			if (g == SQRT_STAGES - 1) begin
				rdy[g] = !vld_s[g] || out_ready;
			end else begin
				rdy[g] = !vld_s[g] || rdy[g+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < SQRT_STAGES; g++) vld_s[g] <= 1'b0;
		end else begin
			for (int g = 0; g < SQRT_STAGES; g++) begin
				if (rdy[g]) begin
					if (g == 0) vld_s[g] <= in_valid;
					else vld_s[g] <= vld_s[g-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < SQRT_STAGES; g++) begin
			if (rdy[g]) stg_s[g] <= nxt[g];
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[SQRT_STAGES-1];
	assign root      = stg_s[SQRT_STAGES-1].root;
	assign x_out     = stg_s[SQRT_STAGES-1].x;
	assign ctl_out   = stg_s[SQRT_STAGES-1].ctl;

endmodule

`default_nettype wire

/* hdl/ofta_cordic.sv */
// ---------------------------------------------------------------------------
// ofta_cordic: pipelined vectoring CORDIC
// Finds atan(y/x) in degrees, two rotations per stage, flags carried along.
// ---------------------------------------------------------------------------
`default_nettype none

module ofta_cordic (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [ofta_pkg::KEEP_BITS-1:0] x_in,
	input  wire  [ofta_pkg::ROOT_W-1:0]    y_in,
	input  ofta_pkg::ctl_t               ctl_in,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic signed [ofta_pkg::Z_W-1:0] z_out,
	output ofta_pkg::ctl_t               ctl_out
);
	import ofta_pkg::*;

	typedef struct packed {
		logic signed [CD_W-1:0] x;
		logic signed [CD_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		ctl_t                   ctl;
	} cd_t;

	cd_t  stg_s [CORDIC_STAGES];
	logic vld_s [CORDIC_STAGES];
	logic rdy   [CORDIC_STAGES];
	cd_t  nxt   [CORDIC_STAGES];

	// shift that truncates toward zero
	function automatic logic signed [CD_W-1:0] shr_tz(input logic signed [CD_W-1:0] v,
			input int s);
		logic signed [CD_W-1:0] r;
		if (v < 0) r = -((-v) >>> s);
		else r = v >>> s;
		return r;
	endfunction

	function automatic cd_t cd_stage(input cd_t s, input int g);
		cd_t                    r;
		logic signed [CD_W-1:0] nx;
		int                     i;
		r = s;
		for (int k = 0; k < 2; k++) begin
			i = 2 * g + k;
			// hold once y has reached zero
			if (r.y > 0) begin
				nx  = r.x + shr_tz(r.y, i);
				r.y = r.y - shr_tz(r.x, i);
				r.z = r.z + $signed(ATAN_DEG[i]);
				r.x = nx;
			end else if (r.y < 0) begin
				nx  = r.x - shr_tz(r.y, i);
				r.y = r.y + shr_tz(r.x, i);
				r.z = r.z - $signed(ATAN_DEG[i]);
				r.x = nx;
			end
		end
		return r;
	endfunction

	always_comb begin
		cd_t src;
		for (int g = 0; g < CORDIC_STAGES; g++) begin
			if (g == 0) begin
				src.x   = $signed(CD_W'(x_in));
				src.y   = $signed(CD_W'(y_in));
				src.z   = '0;
				src.ctl = ctl_in;
			end else begin
				src = stg_s[g-1];
			end
			nxt[g] = cd_stage(src, g);
		end
	end

	always_comb begin
		for (int g = CORDIC_STAGES - 1; g >= 0; g--) begin
			if (g == CORDIC_STAGES - 1) begin
				rdy[g] = !vld_s[g] || out_ready;
			end else begin
				rdy[g] = !vld_s[g] || rdy[g+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < CORDIC_STAGES; g++) vld_s[g] <= 1'b0;
		end else begin
			for (int g = 0; g < CORDIC_STAGES; g++) begin
				if (rdy[g]) begin
					if (g == 0) vld_s[g] <= in_valid;
					else vld_s[g] <= vld_s[g-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < CORDIC_STAGES; g++) begin
			if (rdy[g]) stg_s[g] <= nxt[g];
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[CORDIC_STAGES-1];
	assign z_out     = stg_s[CORDIC_STAGES-1].z;
	assign ctl_out   = stg_s[CORDIC_STAGES-1].ctl;

endmodule

`default_nettype wire
